// ----- rtl/homogeneous_vertex_transform_macros.svh -----
// Assertion macros shared by the vertex transform RTL.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define HVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, disabled during reset.
`define HVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/hvt_pkg.sv -----
// Shared types and constants of the vertex transform.
package hvt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STAGES = NUM_W + 2;
    localparam int PIPE_DEPTH = DIV_STAGES + 2;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = 6;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef fix_t [3:0] vec4_t;

    localparam fix_t FIX_ONE = fix_t'(64'sd1 <<< FRAC_BITS);
    localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [63:0] REG_ONE_LO = {32'd0, FIX_ONE};
    localparam logic [63:0] REG_ONE_HI = {FIX_ONE, 32'd0};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5,
        REG_ROW3_COLS01 = 3'd6,
        REG_ROW3_COLS23 = 3'd7
    } reg_idx_t;

    typedef struct packed {
        fix_t res;
        logic sat;
        logic dz;
    } lane_out_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [NUM_W-1:0]  nq;
        logic [DATA_W-1:0] den;
        fix_t              num;
        logic              neg;
        logic              zero;
        logic              point;
        logic              sat;
    } div_stage_t;

endpackage

// ----- rtl/hvt_dot_lane.sv -----
// One matrix row times the input vector: multiply stage, then sum, shift and clamp.
module hvt_dot_lane (
    input  logic           clk,
    input  logic           en_prod,
    input  logic           en_sum,
    input  hvt_pkg::vec4_t row,
    input  hvt_pkg::vec4_t vec,
    output hvt_pkg::fix_t  res,
    output logic           sat
);

    localparam logic signed [hvt_pkg::SUM_W-1:0] SUM_MAX =
        hvt_pkg::SUM_W'(hvt_pkg::FIX_MAX);
    localparam logic signed [hvt_pkg::SUM_W-1:0] SUM_MIN =
        hvt_pkg::SUM_W'(hvt_pkg::FIX_MIN);

    logic signed [hvt_pkg::PROD_W-1:0] prod_reg [4];
    logic signed [hvt_pkg::PROD_W-1:0] prod_next [4];
    logic signed [hvt_pkg::SUM_W-1:0]  sum;
    logic signed [hvt_pkg::SUM_W-1:0]  shifted;
    hvt_pkg::fix_t                     res_reg, res_next;
    logic                              sat_reg, sat_next;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod_next[c] = row[c] * vec[c];
        end
    end

    always_comb
    begin
        sum = hvt_pkg::SUM_W'(prod_reg[0]) + hvt_pkg::SUM_W'(prod_reg[1])
            + hvt_pkg::SUM_W'(prod_reg[2]) + hvt_pkg::SUM_W'(prod_reg[3]);
        shifted = sum >>> hvt_pkg::FRAC_BITS;
        if (shifted > SUM_MAX)
        begin
            res_next = hvt_pkg::FIX_MAX;
            sat_next = 1'b1;
        end
        else if (shifted < SUM_MIN)
        begin
            res_next = hvt_pkg::FIX_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            res_next = shifted[hvt_pkg::DATA_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (en_sum)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/hvt_div_lane.sv -----
// Pipelined restoring divider for one component, one quotient bit per stage.
module hvt_div_lane (
    input  logic                              clk,
    input  logic [hvt_pkg::DIV_STAGES-1:0]    en,
    input  logic                              point,
    input  logic                              sat_in,
    input  hvt_pkg::fix_t                     num,
    input  hvt_pkg::fix_t                     den,
    output hvt_pkg::lane_out_t                out
);

    localparam int NW = hvt_pkg::NUM_W;
    localparam logic [NW-1:0] Q_POS_MAX = NW'(hvt_pkg::FIX_MAX);
    localparam logic [NW-1:0] Q_NEG_MAX = NW'(1) << (hvt_pkg::DATA_W - 1);

    hvt_pkg::div_stage_t stg_reg  [NW+1];
    hvt_pkg::div_stage_t stg_next [NW+1];
    hvt_pkg::lane_out_t  out_reg, out_next;
    logic [hvt_pkg::DATA_W:0] trial [1:NW];
    logic                     ge    [1:NW];
    hvt_pkg::div_stage_t      last;
    logic [hvt_pkg::DATA_W-1:0] num_abs;

    // prepare magnitudes and signs, then one quotient bit per stage
    always_comb
    begin
        num_abs = num[hvt_pkg::DATA_W-1] ? hvt_pkg::DATA_W'(-num) : num;
        stg_next[0].rem   = '0;
        stg_next[0].nq    = {num_abs, {hvt_pkg::FRAC_BITS{1'b0}}};
        stg_next[0].den   = den[hvt_pkg::DATA_W-1] ? hvt_pkg::DATA_W'(-den) : den;
        stg_next[0].num   = num;
        stg_next[0].neg   = num[hvt_pkg::DATA_W-1] ^ den[hvt_pkg::DATA_W-1];
        stg_next[0].zero  = (den == '0);
        stg_next[0].point = point;
        stg_next[0].sat   = sat_in;
        for (int k = 1; k <= NW; k++)
        begin
            trial[k] = {stg_reg[k-1].rem, stg_reg[k-1].nq[NW-1]};
            ge[k]    = trial[k] >= {1'b0, stg_reg[k-1].den};
            stg_next[k]     = stg_reg[k-1];
            stg_next[k].rem = ge[k] ? hvt_pkg::DATA_W'(trial[k] - {1'b0, stg_reg[k-1].den})
                                    : trial[k][hvt_pkg::DATA_W-1:0];
            stg_next[k].nq  = {stg_reg[k-1].nq[NW-2:0], ge[k]};
        end
    end

    // for points apply sign, clamp and the zero-divisor case; other kinds pass num through
    always_comb
    begin
        last = stg_reg[NW];
        out_next.res = last.num;
        out_next.sat = last.sat;
        out_next.dz  = 1'b0;
        if (last.point)
        begin
            if (last.zero)
            begin
                out_next.dz = 1'b1;
                if (last.num == '0)
                begin
                    out_next.res = '0;
                end
                else
                begin
                    out_next.res = last.num[hvt_pkg::DATA_W-1] ? hvt_pkg::FIX_MIN
                                                                : hvt_pkg::FIX_MAX;
                    out_next.sat = 1'b1;
                end
            end
            else if (last.neg)
            begin
                if (last.nq > Q_NEG_MAX)
                begin
                    out_next.res = hvt_pkg::FIX_MIN;
                    out_next.sat = 1'b1;
                end
                else
                begin
                    out_next.res = hvt_pkg::DATA_W'(-last.nq[hvt_pkg::DATA_W-1:0]);
                end
            end
            else
            begin
                if (last.nq > Q_POS_MAX)
                begin
                    out_next.res = hvt_pkg::FIX_MAX;
                    out_next.sat = 1'b1;
                end
                else
                begin
                    out_next.res = last.nq[hvt_pkg::DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NW; k++)
        begin
            if (en[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
        if (en[NW+1])
        begin
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

// ----- rtl/homogeneous_vertex_transform.sv -----
// Top level of the 4x4 homogeneous vertex transform with point divide.
//
// Usage:
//   Vertices enter on the s_ stream: s_tdata carries x, y, z, w (Q16.16),
//   s_tuser carries the kind (0 = vector, 1 = point with divide by w).
//   Results leave on the m_ stream: m_tdata carries x, y, z, w and
//   m_tuser carries the saturated and divide-by-zero flags.
//   The matrix is held in eight 64-bit registers on the APB port, two
//   entries each, even column in the low half. Write only while idle.
// Timing:
//   PIPE_DEPTH = 52 register stages; a request passes through all of them
//   before it leaves on the m_ stream.
//   One request per cycle is sustained while m_tready stays high; the
//   rate is set by the multiply stage of the four row lanes and the
//   divider pipeline with its 48 quotient-bit stages, one bit per stage.
// Reset:
//   Clears every stage valid bit and loads the identity matrix.
// Stall:
//   Each stage holds while the one after it is full and stalled, so
//   bubbles collapse and s_tready drops only once every stage is full
//   behind a stalled m_tready.
`include "homogeneous_vertex_transform_macros.svh"

module homogeneous_vertex_transform (
    input  logic                      clk,
    input  logic                      rst_n,
    // APB configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hvt_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [127:0]              s_tdata,   // in_x, in_y, in_z, in_w
    input  logic                      s_tuser,   // kind
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [127:0]              m_tdata,   // out_x, out_y, out_z, out_w
    output logic [1:0]                m_tuser    // saturated, divide_by_zero
);

    localparam int NST = hvt_pkg::PIPE_DEPTH;

    logic [63:0]                   mat_reg  [hvt_pkg::NUM_REGS];
    logic [hvt_pkg::REG_IDX_W-1:0] cfg_idx;
    logic                          cfg_wr;
    logic [NST-1:0]                v_reg, v_next;
    logic [NST-1:0]                en;
    logic                          point0_reg, point1_reg;
    hvt_pkg::vec4_t                vec;
    hvt_pkg::vec4_t                rows [4];
    hvt_pkg::fix_t                 dot_res [4];
    logic                          dot_sat [4];
    hvt_pkg::fix_t                 w_num;
    hvt_pkg::lane_out_t            lane_out [4];

    // APB register file
    assign pready  = 1'b1;
    assign cfg_idx = paddr[hvt_pkg::ADDR_W-1:hvt_pkg::ADDR_W-hvt_pkg::REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = mat_reg[cfg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hvt_pkg::NUM_REGS; i++)
            begin
                mat_reg[i] <= '0;
            end
            mat_reg[hvt_pkg::REG_ROW0_COLS01] <= hvt_pkg::REG_ONE_LO;
            mat_reg[hvt_pkg::REG_ROW1_COLS01] <= hvt_pkg::REG_ONE_HI;
            mat_reg[hvt_pkg::REG_ROW2_COLS23] <= hvt_pkg::REG_ONE_LO;
            mat_reg[hvt_pkg::REG_ROW3_COLS23] <= hvt_pkg::REG_ONE_HI;
        end
        else if (cfg_wr)
        begin
            mat_reg[cfg_idx] <= pwdata;
        end
    end

    // unpack the matrix rows
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            rows[r][0] = mat_reg[2*r][31:0];
            rows[r][1] = mat_reg[2*r][63:32];
            rows[r][2] = mat_reg[2*r+1][31:0];
            rows[r][3] = mat_reg[2*r+1][63:32];
        end
    end

    // stage enables: a stage advances when empty or when its successor advances
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int j = NST - 2; j >= 0; j--)
        begin
            en[j] = !v_reg[j] || en[j+1];
        end
        v_next[0] = s_tvalid;
        for (int j = 1; j < NST; j++)
        begin
            v_next[j] = v_reg[j-1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < NST; j++)
            begin
                if (en[j])
                begin
                    v_reg[j] <= v_next[j];
                end
            end
        end
    end

    // force w to one for points
    always_comb
    begin
        vec[0] = s_tdata[31:0];
        vec[1] = s_tdata[63:32];
        vec[2] = s_tdata[95:64];
        vec[3] = s_tuser ? hvt_pkg::FIX_ONE : s_tdata[127:96];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            point0_reg <= s_tuser;
        end
        if (en[1])
        begin
            point1_reg <= point0_reg;
        end
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_dot
        hvt_dot_lane u_dot (
            .clk     (clk),
            .en_prod (en[0]),
            .en_sum  (en[1]),
            .row     (rows[r]),
            .vec     (vec),
            .res     (dot_res[r]),
            .sat     (dot_sat[r])
        );
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        hvt_div_lane u_div (
            .clk    (clk),
            .en     (en[NST-1:2]),
            .point  (point1_reg),
            .sat_in (dot_sat[i]),
            .num    (dot_res[i]),
            .den    (dot_res[3]),
            .out    (lane_out[i])
        );
    end

    // w rides the same pipeline as a pass-through lane
    assign w_num = point1_reg ? hvt_pkg::FIX_ONE : dot_res[3];

    hvt_div_lane u_div_w (
        .clk    (clk),
        .en     (en[NST-1:2]),
        .point  (1'b0),
        .sat_in (dot_sat[3]),
        .num    (w_num),
        .den    (dot_res[3]),
        .out    (lane_out[3])
    );

    // merge the lane results and flags
    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = {lane_out[3].res, lane_out[2].res, lane_out[1].res, lane_out[0].res};
    assign m_tuser  = {lane_out[0].dz,
                       lane_out[0].sat | lane_out[1].sat | lane_out[2].sat | lane_out[3].sat};

    `HVT_ASSERT_IMP(a_full_when_blocked, !s_tready, m_tvalid && !m_tready)
    `HVT_ASSERT_IMP(a_dz_means_unit_w, m_tvalid && m_tuser[1],
                    m_tdata[127:96] == hvt_pkg::FIX_ONE)
    `HVT_ASSERT_IMP(a_dz_lanes_agree, m_tvalid, lane_out[0].dz == lane_out[1].dz)
    `HVT_ASSERT_NXT(a_cfg_written, cfg_wr, mat_reg[$past(cfg_idx)] == $past(pwdata))

endmodule

// ----- test/tb_homogeneous_vertex_transform.sv -----
// Testbench for the homogeneous vertex transform: random vertices against a local predictor.
`timescale 1ns / 1ps

module tb_homogeneous_vertex_transform;

    // Predicted result of one vertex request.
    typedef struct {
        logic [31:0] x, y, z, w;
        logic        sat, dz;
    } vertex_result_t;

    // Matrix copy, the predictor and the queue of expected vertices.
    class vertex_scoreboard;
        logic [63:0]    mat [8];
        vertex_result_t pending [$];
        int             errors;

        function new();
            errors = 0;
            foreach (mat[i]) mat[i] = 64'd0;
            mat[hvt_pkg::REG_ROW0_COLS01] = hvt_pkg::REG_ONE_LO;
            mat[hvt_pkg::REG_ROW1_COLS01] = hvt_pkg::REG_ONE_HI;
            mat[hvt_pkg::REG_ROW2_COLS23] = hvt_pkg::REG_ONE_LO;
            mat[hvt_pkg::REG_ROW3_COLS23] = hvt_pkg::REG_ONE_HI;
        endfunction

        function logic signed [63:0] entry(int r, int c);
            logic [63:0] reg_val;
            reg_val = mat[r * 2 + c / 2];
            return (c % 2) ? 64'(signed'(reg_val[63:32])) : 64'(signed'(reg_val[31:0]));
        endfunction

        // Clamp to 32 bits, flag on clamp.
        function logic signed [63:0] clamp(logic signed [95:0] v, ref logic sat);
            if (v > 96'sd2147483647)
            begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -96'sd2147483648)
            begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return 64'(v);
        endfunction

        // Note an accepted vertex and predict its result.
        function void note_vertex(logic kind, logic [127:0] data);
            logic signed [63:0] v [4];
            logic signed [63:0] res [4];
            logic signed [95:0] acc;
            logic signed [95:0] q;
            logic [95:0]        n, d, uq;
            logic               sat, dz, neg;
            vertex_result_t     e;
            sat = 1'b0;
            dz = 1'b0;
            for (int i = 0; i < 4; i++) v[i] = 64'(signed'(data[32*i +: 32]));
            if (kind) v[3] = 64'sd1 <<< hvt_pkg::FRAC_BITS;
            for (int r = 0; r < 4; r++)
            begin
                acc = 0;
                for (int c = 0; c < 4; c++) acc += 96'(entry(r, c)) * 96'(v[c]);
                res[r] = clamp(acc >>> hvt_pkg::FRAC_BITS, sat);
            end
            if (kind)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (res[3] == 0)
                    begin
                        dz = 1'b1;
                        if (res[i] > 0)
                        begin
                            res[i] = 64'sd2147483647;
                            sat = 1'b1;
                        end
                        else if (res[i] < 0)
                        begin
                            res[i] = -64'sd2147483648;
                            sat = 1'b1;
                        end
                    end
                    else
                    begin
                        neg = (res[i] < 0) != (res[3] < 0);
                        n = 96'(res[i] < 0 ? -res[i] : res[i]) << hvt_pkg::FRAC_BITS;
                        d = 96'(res[3] < 0 ? -res[3] : res[3]);
                        uq = n / d;
                        if (uq > 96'h1_0000_0000) uq = 96'h1_0000_0000;
                        q = neg ? -$signed(uq) : $signed(uq);
                        res[i] = clamp(q, sat);
                    end
                end
                res[3] = 64'sd1 <<< hvt_pkg::FRAC_BITS;
            end
            e.x = res[0][31:0];
            e.y = res[1][31:0];
            e.z = res[2][31:0];
            e.w = res[3][31:0];
            e.sat = sat;
            e.dz = dz;
            pending.push_back(e);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [127:0] data, logic [1:0] flags);
            vertex_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h flags %b", $time, data, flags);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.x)
            begin
                $display("%0t: out_x expected %h actual %h", $time, e.x, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.y)
            begin
                $display("%0t: out_y expected %h actual %h", $time, e.y, data[63:32]);
                errors++;
            end
            if (data[95:64] !== e.z)
            begin
                $display("%0t: out_z expected %h actual %h", $time, e.z, data[95:64]);
                errors++;
            end
            if (data[127:96] !== e.w)
            begin
                $display("%0t: out_w expected %h actual %h", $time, e.w, data[127:96]);
                errors++;
            end
            if (flags[0] !== e.sat)
            begin
                $display("%0t: saturated expected %b actual %b", $time, e.sat, flags[0]);
                errors++;
            end
            if (flags[1] !== e.dz)
            begin
                $display("%0t: divide_by_zero expected %b actual %b", $time, e.dz, flags[1]);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       psel, penable, pwrite;
    logic [hvt_pkg::ADDR_W-1:0] paddr;
    logic [63:0]                pwdata;
    logic [63:0]                prdata;
    logic                       pready;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [127:0]               s_tdata;   // in_x, in_y, in_z, in_w
    logic                       s_tuser;   // kind
    logic                       m_tvalid;
    logic                       m_tready;
    logic [127:0]               m_tdata;   // out_x, out_y, out_z, out_w
    logic [1:0]                 m_tuser;   // saturated, divide_by_zero

    vertex_scoreboard   board;
    bit                 no_stall;   // suppress random idling on both sides

    homogeneous_vertex_transform DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous fixed limit on the whole run.
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: stall at random, check every accepted result.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
            m_tready <= no_stall || ($urandom_range(99) >= 32);
        end
    end

    // Write one matrix register through a setup and an access cycle.
    task automatic write_reg(hvt_pkg::reg_idx_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hvt_pkg::ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.mat[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one vertex, hold until accepted; random gaps in front of it.
    task automatic send_vertex(logic kind, logic [127:0] data);
        while (!no_stall && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        board.note_vertex(kind, data);
    endtask

    // Wait until every prediction has been consumed, then let the pipe drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (hvt_pkg::PIPE_DEPTH + 8) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(8 << 16)) - (4 << 16));
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [63:0] rand_entry_pair(int mode);
        logic [31:0] a, b;
        if (mode == 0)
        begin
            a = rand_comp();
            b = rand_comp();
        end
        else
        begin
            // Small entries keep most results in range.
            a = 32'(signed'($urandom_range(4 << 16)) - (2 << 16));
            b = 32'(signed'($urandom_range(4 << 16)) - (2 << 16));
        end
        return {b, a};
    endfunction

    task automatic random_vertices(int count);
        logic [127:0] d;
        for (int i = 0; i < count; i++)
        begin
            d = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            send_vertex(1'($urandom_range(1)), d);
        end
    endtask

    initial
    begin
        board    = new();
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        no_stall = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity matrix, extremes, unit w.
        send_vertex(1'b0, {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        send_vertex(1'b0, {32'hffff_ffff, 32'h0001_0000, 32'd0, 32'hffff_ffff});
        send_vertex(1'b1, {32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 32'h0003_0000});
        send_vertex(1'b1, {32'hffff_ffff, 32'd0, 32'hfffe_0000, 32'h0002_8000});
        drain();

        // Directed: w row all zero, so every point divides by zero.
        write_reg(hvt_pkg::REG_ROW3_COLS01, 64'd0);
        write_reg(hvt_pkg::REG_ROW3_COLS23, 64'd0);
        send_vertex(1'b1, {32'd0, 32'd0, 32'hffff_0000, 32'h0001_0000});
        send_vertex(1'b1, {32'd5, 32'h7fff_ffff, 32'h8000_0000, 32'd0});
        send_vertex(1'b0, {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        drain();

        // Directed: extreme matrix entries, small w so divides saturate.
        write_reg(hvt_pkg::REG_ROW0_COLS01, 64'h8000_0000_7fff_ffff);
        write_reg(hvt_pkg::REG_ROW0_COLS23, 64'h7fff_ffff_8000_0000);
        write_reg(hvt_pkg::REG_ROW1_COLS01, 64'hffff_ffff_ffff_ffff);
        write_reg(hvt_pkg::REG_ROW1_COLS23, 64'h8000_0000_8000_0000);
        write_reg(hvt_pkg::REG_ROW2_COLS01, 64'h7fff_ffff_7fff_ffff);
        write_reg(hvt_pkg::REG_ROW2_COLS23, 64'h0000_0000_0000_0001);
        write_reg(hvt_pkg::REG_ROW3_COLS01, 64'd0);
        write_reg(hvt_pkg::REG_ROW3_COLS23, 64'h0000_0001_0000_0000);
        send_vertex(1'b1, {32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        send_vertex(1'b1, {32'd0, 32'hffff_ffff, 32'h0001_0000, 32'h8000_0000});
        send_vertex(1'b0, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_vertex(1'b0, {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
        drain();

        // Random phases: new matrix each, one phase without any idling.
        for (int ph = 0; ph < 12; ph++)
        begin
            for (int r = 0; r < hvt_pkg::NUM_REGS; r++)
                write_reg(hvt_pkg::reg_idx_t'(r), rand_entry_pair(ph % 3 == 0 ? 0 : 1));
            no_stall = (ph == 5);
            random_vertices(150);
            if (ph == 7)
            begin
                // Hold off the sender until everything has come back.
                s_tvalid <= 1'b0;
                while (board.pending.size() != 0) @(posedge clk);
                random_vertices(10);
            end
            drain();
            no_stall = 1'b0;
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
